[rtl/core/maze_row_generator_defines.svh]
// Assertion macros for the maze row generator checker.
`ifndef MAZE_ROW_GENERATOR_DEFINES_SVH
`define MAZE_ROW_GENERATOR_DEFINES_SVH

// Check a property on the rising clock edge, ignored while reset is asserted.
`define MRG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the rising clock edge, reset included.
`define MRG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/mrg_pkg.sv]
// Types, constants and item layouts shared by the maze row generator.
`default_nettype none

package mrg_pkg;

  // Row geometry and field widths
  localparam int CELLS   = 16;
  localparam int IDX_W   = $clog2(CELLS);
  localparam int LABEL_W = 5;
  localparam int WIDTH_W = 5;
  localparam int MERGE_W = 15;
  localparam int DOWN_W  = 16;

  localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET = WIDTH_W'(16);
  localparam logic [WIDTH_W-1:0] ROW_WIDTH_MIN   = WIDTH_W'(2);

  // Row kinds carried in the action field
  localparam logic [1:0] ACT_FIRST  = 2'd0;
  localparam logic [1:0] ACT_MIDDLE = 2'd1;
  localparam logic [1:0] ACT_LAST   = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [MERGE_W-1:0] merge_bits;
    logic [DOWN_W-1:0]  down_bits;
  } in_item_t;

  typedef struct packed {
    logic [MERGE_W-1:0] right_walls;
    logic [DOWN_W-1:0]  bottom_walls;
    logic               bottom_valid;
  } out_item_t;

  // Operation applied to the label row in one scan step
  typedef enum logic [1:0] {
    ROW_HOLD  = 2'd0,
    ROW_FIRST = 2'd1,
    ROW_FRESH = 2'd2,
    ROW_MERGE = 2'd3
  } row_mode_e;

  typedef struct packed {
    logic               start;
    logic               step;
    logic               apply;
    row_mode_e          mode;
    logic [LABEL_W-1:0] label;
  } row_ctl_t;

endpackage

`default_nettype wire

[rtl/core/mrg_label_row.sv]
// Rotating row of cell labels with parallel relabel and fresh-label search.
`default_nettype none

module mrg_label_row (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mrg_pkg::row_ctl_t             ctl_i,
  input  logic [mrg_pkg::WIDTH_W-1:0]   width_i,
  output logic                          differ_o
);

  logic [mrg_pkg::LABEL_W-1:0] lab_q [mrg_pkg::CELLS];
  logic [mrg_pkg::LABEL_W-1:0] lab_d [mrg_pkg::CELLS];
  logic [mrg_pkg::LABEL_W-1:0] upd   [mrg_pkg::CELLS];
  logic [mrg_pkg::CELLS-1:0]   use_q, use_d;
  logic [mrg_pkg::CELLS-1:0]   used;
  logic [mrg_pkg::IDX_W-1:0]   fresh;
  logic                        found;

  // Position 0 holds the current cell, position 1 its right neighbor
  assign differ_o = (lab_q[0] != lab_q[1]);

  // Collect labels held by the other cells in use
  always_comb begin
    used = '0;
    for (int p = 1; p < mrg_pkg::CELLS; p++) begin
      if (use_q[p] && (lab_q[p] < mrg_pkg::LABEL_W'(mrg_pkg::CELLS))) begin
        used[lab_q[p][mrg_pkg::IDX_W-1:0]] = 1'b1;
      end
    end
  end

  // Pick the smallest free label
  always_comb begin
    fresh = '0;
    found = 1'b0;
    for (int k = 0; k < mrg_pkg::CELLS; k++) begin
      if (!found && !used[k]) begin
        fresh = mrg_pkg::IDX_W'(k);
        found = 1'b1;
      end
    end
  end

  // Apply this step's operation to the row
  always_comb begin
    for (int p = 0; p < mrg_pkg::CELLS; p++) begin
      upd[p] = lab_q[p];
    end
    if (ctl_i.apply) begin
      unique case (ctl_i.mode)
        mrg_pkg::ROW_HOLD: ;
        mrg_pkg::ROW_FIRST: upd[0] = ctl_i.label;
        mrg_pkg::ROW_FRESH: upd[0] = mrg_pkg::LABEL_W'(fresh);
        mrg_pkg::ROW_MERGE: begin
          for (int p = 0; p < mrg_pkg::CELLS; p++) begin
            if (use_q[p] && (lab_q[p] == lab_q[1])) begin
              upd[p] = lab_q[0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Load the in-use mask on start, rotate the row by one cell on each step
  always_comb begin
    use_d = use_q;
    for (int p = 0; p < mrg_pkg::CELLS; p++) begin
      lab_d[p] = lab_q[p];
    end
    if (ctl_i.start) begin
      for (int p = 0; p < mrg_pkg::CELLS; p++) begin
        use_d[p] = (mrg_pkg::WIDTH_W'(p) < width_i);
      end
    end else if (ctl_i.step) begin
      for (int p = 0; p < mrg_pkg::CELLS - 1; p++) begin
        lab_d[p] = upd[p+1];
      end
      lab_d[mrg_pkg::CELLS-1] = upd[0];
      use_d = {use_q[0], use_q[mrg_pkg::CELLS-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_q <= '0;
      for (int p = 0; p < mrg_pkg::CELLS; p++) begin
        lab_q[p] <= '0;
      end
    end else begin
      use_q <= use_d;
      for (int p = 0; p < mrg_pkg::CELLS; p++) begin
        lab_q[p] <= lab_d[p];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/maze_row_generator.sv]
// Scans: a first row takes one scan of 16 cells from acceptance to a valid result, a middle
// or last row two scans (bottom walls, then merges). A new item is taken only once the
// result is in the output register; the label row steps one cell per cycle
// through a single shared relabel and fresh-label unit.
// Reset: labels clear to zero, row_width returns to 16, no result is pending.
// Top level of the maze row generator.
`default_nettype none

module maze_row_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mrg_pkg::WIDTH_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mrg_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mrg_pkg::out_item_t            out_item_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_FIRST  = 5'b00010,
    ST_BOTTOM = 5'b00100,
    ST_MERGE  = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

  state_e                      state_q, state_d;
  logic [mrg_pkg::IDX_W-1:0]   step_q, step_d;
  logic                        out_valid_q, out_valid_d;
  logic [mrg_pkg::WIDTH_W-1:0] row_width_q;

  logic [mrg_pkg::CELLS-1:0]   merge_sh_q, merge_sh_d;
  logic [mrg_pkg::CELLS-1:0]   down_sh_q, down_sh_d;
  logic [mrg_pkg::CELLS-1:0]   right_sh_q, right_sh_d;
  logic [mrg_pkg::CELLS-1:0]   bot_sh_q, bot_sh_d;
  logic [mrg_pkg::LABEL_W-1:0] label_cnt_q, label_cnt_d;
  logic                        open_seen_q, open_seen_d;
  logic                        force_q, force_d;
  logic                        first_q, first_d;
  mrg_pkg::out_item_t          out_item_q, out_item_d;

  logic [mrg_pkg::WIDTH_W-1:0] width_eff;
  logic                        in_use, has_next, last_step, in_accept;
  logic                        open_nx, wall_req, wall, do_merge, differ;
  mrg_pkg::row_ctl_t           ctl;

  // Clamp the configured width to the supported range
  always_comb begin
    if (row_width_q < mrg_pkg::ROW_WIDTH_MIN) begin
      width_eff = mrg_pkg::ROW_WIDTH_MIN;
    end else if (row_width_q > mrg_pkg::WIDTH_W'(mrg_pkg::CELLS)) begin
      width_eff = mrg_pkg::WIDTH_W'(mrg_pkg::CELLS);
    end else begin
      width_eff = row_width_q;
    end
  end

  assign in_use    = (mrg_pkg::WIDTH_W'(step_q) < width_eff);
  assign has_next  = ((mrg_pkg::WIDTH_W'(step_q) + mrg_pkg::WIDTH_W'(1)) < width_eff);
  assign last_step = (step_q == mrg_pkg::IDX_W'(mrg_pkg::CELLS - 1));
  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign open_nx   = open_seen_q || !down_sh_q[0];
  assign wall_req  = down_sh_q[0];

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  mrg_label_row u_row (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .width_i  (width_eff),
    .differ_o (differ)
  );

  // Sequence the scans over the row
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    merge_sh_d  = merge_sh_q;
    down_sh_d   = down_sh_q;
    right_sh_d  = right_sh_q;
    bot_sh_d    = bot_sh_q;
    label_cnt_d = label_cnt_q;
    open_seen_d = open_seen_q;
    force_d     = force_q;
    first_d     = first_q;
    out_item_d  = out_item_q;
    wall        = 1'b0;
    do_merge    = 1'b0;
    ctl         = '{start: 1'b0, step: 1'b0, apply: 1'b0,
                    mode: mrg_pkg::ROW_HOLD, label: '0};

    // Drop the result once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          ctl.start   = 1'b1;
          step_d      = '0;
          merge_sh_d  = mrg_pkg::CELLS'(in_item_i.merge_bits);
          down_sh_d   = mrg_pkg::CELLS'(in_item_i.down_bits);
          right_sh_d  = '0;
          bot_sh_d    = '0;
          label_cnt_d = '0;
          open_seen_d = 1'b0;
          force_d     = (in_item_i.action != mrg_pkg::ACT_MIDDLE);
          first_d     = (in_item_i.action == mrg_pkg::ACT_FIRST);
          state_d     = (in_item_i.action == mrg_pkg::ACT_FIRST) ? ST_FIRST : ST_BOTTOM;
        end
      end
      ST_FIRST: begin
        // Label runs left to right, wall where requested
        wall       = has_next && merge_sh_q[0];
        ctl.step   = 1'b1;
        ctl.apply  = in_use;
        ctl.mode   = mrg_pkg::ROW_FIRST;
        ctl.label  = label_cnt_q;
        if (wall) begin
          label_cnt_d = label_cnt_q + mrg_pkg::LABEL_W'(1);
        end
        right_sh_d = {wall, right_sh_q[mrg_pkg::CELLS-1:1]};
        merge_sh_d = {1'b0, merge_sh_q[mrg_pkg::CELLS-1:1]};
        step_d     = step_q + mrg_pkg::IDX_W'(1);
        if (last_step) begin
          state_d = ST_DONE;
        end
      end
      ST_BOTTOM: begin
        // Keep at least one opening per run, give walled cells a fresh label
        if (in_use) begin
          if (has_next && !differ) begin
            wall        = wall_req;
            open_seen_d = open_nx;
          end else begin
            wall        = wall_req && open_nx;
            open_seen_d = 1'b0;
          end
        end
        ctl.step  = 1'b1;
        ctl.apply = wall;
        ctl.mode  = mrg_pkg::ROW_FRESH;
        bot_sh_d  = {wall, bot_sh_q[mrg_pkg::CELLS-1:1]};
        down_sh_d = {1'b0, down_sh_q[mrg_pkg::CELLS-1:1]};
        step_d    = step_q + mrg_pkg::IDX_W'(1);
        if (last_step) begin
          state_d = ST_MERGE;
        end
      end
      ST_MERGE: begin
        // Merge differing neighbors on request or on a last row, else wall
        do_merge   = has_next && differ && (force_q || merge_sh_q[0]);
        wall       = has_next && !do_merge;
        ctl.step   = 1'b1;
        ctl.apply  = do_merge;
        ctl.mode   = mrg_pkg::ROW_MERGE;
        right_sh_d = {wall, right_sh_q[mrg_pkg::CELLS-1:1]};
        merge_sh_d = {1'b0, merge_sh_q[mrg_pkg::CELLS-1:1]};
        step_d     = step_q + mrg_pkg::IDX_W'(1);
        if (last_step) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hand the item to the output register once it is free
        if (!out_valid_q || !out_stall_i) begin
          out_item_d.right_walls  = right_sh_q[mrg_pkg::MERGE_W-1:0];
          out_item_d.bottom_walls = bot_sh_q[mrg_pkg::DOWN_W-1:0];
          out_item_d.bottom_valid = !first_q;
          out_valid_d             = 1'b1;
          state_d                 = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      row_width_q <= mrg_pkg::ROW_WIDTH_RESET;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        row_width_q <= cfg_wdata_i;
      end
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    merge_sh_q  <= merge_sh_d;
    down_sh_q   <= down_sh_d;
    right_sh_q  <= right_sh_d;
    bot_sh_q    <= bot_sh_d;
    label_cnt_q <= label_cnt_d;
    open_seen_q <= open_seen_d;
    force_q     <= force_d;
    first_q     <= first_d;
    out_item_q  <= out_item_d;
  end

endmodule

`default_nettype wire

[rtl/core/mrg_checker.sv]
// Port-level checks for the maze row generator, bound to its top level.
`default_nettype none
`include "maze_row_generator_defines.svh"

module mrg_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input mrg_pkg::out_item_t out_item_o
);

  // Hold the result while the receiver stalls
  `MRG_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")
  `MRG_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(out_item_o), "stalled result changed")

  // Check that the input stalls after an item is taken
  `MRG_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o, "input taken during a scan")

  // A first row carries no bottom walls
  `MRG_ASSERT(a_first_no_bottom, clk_i, rst_ni, out_valid_o && !out_item_o.bottom_valid |-> out_item_o.bottom_walls == '0, "bottom walls on a first row")

  // No result while in reset
  `MRG_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !out_valid_o, "result valid in reset")

endmodule

bind maze_row_generator mrg_checker u_mrg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
